FILE: src/euclid_gcd_lcm_fraction_reducer_assert.svh
// Assertion macros shared by the GCD/LCM/fraction reducer RTL.
`ifndef EUCLID_GCD_LCM_FRACTION_REDUCER_ASSERT_SVH
`define EUCLID_GCD_LCM_FRACTION_REDUCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EGL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EGL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/egl_pkg.sv
// Package with widths, request codes and shared types of the GCD/LCM/fraction reducer.
package egl_pkg;

    // Operand width used by the arithmetic (8 to 32); port fields stay fixed.
    localparam int OPW    = 32;
    localparam int W_IN   = 32;
    localparam int W_MAIN = 64;
    localparam int W_REQ  = 2;
    localparam int CNTW   = $clog2(OPW + 1);

    // Request codes.
    localparam logic [W_REQ-1:0] REQ_GCD  = 2'd0;
    localparam logic [W_REQ-1:0] REQ_LCM  = 2'd1;
    localparam logic [W_REQ-1:0] REQ_FRAC = 2'd2;

    // Status returned by the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: src/egl_div.sv
// Shared restoring divider, one quotient bit per cycle.
module egl_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [egl_pkg::OPW-1:0] i_dividend,
    input  logic [egl_pkg::OPW-1:0] i_divisor,
    output logic [egl_pkg::OPW-1:0] o_quotient,
    output logic [egl_pkg::OPW-1:0] o_remainder,
    output egl_pkg::t_div_stat     o_stat
);
    import egl_pkg::*;

    logic [OPW-1:0]  r_rem;
    logic [OPW-1:0]  r_quo;
    logic [OPW-1:0]  r_dvs;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [OPW-1:0]  n_rem;
    logic [OPW-1:0]  n_quo;
    logic [OPW:0]    w_shift;
    logic [OPW:0]    w_diff;

    // One shift-and-subtract step of the restoring division.
    always_comb begin
        w_shift = {r_rem, r_quo[OPW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        if (!w_diff[OPW]) begin
            n_rem = w_diff[OPW-1:0];
            n_quo = {r_quo[OPW-2:0], 1'b1};
        end else begin
            n_rem = w_shift[OPW-1:0];
            n_quo = {r_quo[OPW-2:0], 1'b0};
        end
    end

    // Control: a start loads the operands, then OPW steps run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(OPW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: src/euclid_gcd_lcm_fraction_reducer.sv
// Top level: sequencer around the shared divider for GCD, LCM and fraction reduction.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   i_req_type, i_operand_a, i_operand_b
//  output   out        o_valid / i_stall   o_result_main, o_result_second, o_div_zero
//
// Each division on the shared divider runs a load, OPW steps and a done strobe.
// A request runs k remainder divisions for the GCD, two more (a/g, b/g) for a fraction,
// or one more (a/g) plus a multiply state for the LCM.
// A zero second operand skips the divider and goes straight to the result state.
// The input stalls from acceptance until the result transaction completes.
// Reset is synchronous and active low; it empties the block.
module euclid_gcd_lcm_fraction_reducer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [egl_pkg::W_REQ-1:0] i_req_type,
    input  logic [egl_pkg::W_IN-1:0]  i_operand_a,
    input  logic [egl_pkg::W_IN-1:0]  i_operand_b,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [egl_pkg::W_MAIN-1:0] o_result_main,
    output logic [egl_pkg::W_IN-1:0]  o_result_second,
    output logic                      o_div_zero
);
    import egl_pkg::*;

    `include "euclid_gcd_lcm_fraction_reducer_assert.svh"

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EUC  = 6'b000010,
        ST_QA   = 6'b000100,
        ST_QB   = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic             r_go, n_go;
    logic [W_REQ-1:0] r_req, n_req;
    logic [OPW-1:0]   r_sa, n_sa;
    logic [OPW-1:0]   r_sb, n_sb;
    logic [OPW-1:0]   r_dvd, n_dvd;
    logic [OPW-1:0]   r_dvs, n_dvs;
    logic [OPW-1:0]   r_qa, n_qa;
    logic [W_MAIN-1:0] r_main, n_main;
    logic [OPW-1:0]   r_second, n_second;
    logic             r_flag, n_flag;

    logic [OPW-1:0]   w_a, w_b;
    logic [OPW-1:0]   w_div_dvd, w_div_dvs;
    logic [OPW-1:0]   w_div_quo, w_div_rem;
    t_div_stat        w_div_stat;
    logic [2*OPW-1:0] w_prod;

    // Only the low OPW bits of each operand take part.
    assign w_a = i_operand_a[OPW-1:0];
    assign w_b = i_operand_b[OPW-1:0];

    // Operand selection for the shared divider.
    always_comb begin
        case (r_state)
            ST_QA: begin
                w_div_dvd = r_sa;
                w_div_dvs = r_dvd;
            end
            ST_QB: begin
                w_div_dvd = r_sb;
                w_div_dvs = r_dvd;
            end
            default: begin
                w_div_dvd = r_dvd;
                w_div_dvs = r_dvs;
            end
        endcase
    end

    egl_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_go),
        .i_dividend  (w_div_dvd),
        .i_divisor   (w_div_dvs),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem),
        .o_stat      (w_div_stat)
    );

    // LCM as (a / g) * b, which is exact since g divides a.
    assign w_prod = (2*OPW)'(r_qa) * (2*OPW)'(r_sb);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        n_req    = r_req;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_dvd    = r_dvd;
        n_dvs    = r_dvs;
        n_qa     = r_qa;
        n_main   = r_main;
        n_second = r_second;
        n_flag   = r_flag;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req_type;
                    n_sa     = w_a;
                    n_sb     = w_b;
                    n_main   = '0;
                    n_second = '0;
                    n_dvd    = w_a;
                    if (w_b == '0) begin
                        n_dvs   = '0;
                        n_flag  = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_dvs   = w_b;
                        n_flag  = 1'b0;
                        n_go    = 1'b1;
                        n_state = ST_EUC;
                    end
                end
            end
            ST_EUC: begin
                if (w_div_stat.done) begin
                    n_dvd = r_dvs;
                    n_dvs = w_div_rem;
                    if (w_div_rem == '0) begin
                        case (r_req) inside
                            REQ_GCD: begin
                                n_main  = W_MAIN'(r_dvs);
                                n_state = ST_OUT;
                            end
                            REQ_LCM, REQ_FRAC: begin
                                n_go    = 1'b1;
                                n_state = ST_QA;
                            end
                            default: begin
                                n_state = ST_OUT;
                            end
                        endcase
                    end else begin
                        n_go = 1'b1;
                    end
                end
            end
            ST_QA: begin
                if (w_div_stat.done) begin
                    n_qa = w_div_quo;
                    if (r_req == REQ_LCM) begin
                        n_state = ST_MUL;
                    end else begin
                        n_go    = 1'b1;
                        n_state = ST_QB;
                    end
                end
            end
            ST_QB: begin
                if (w_div_stat.done) begin
                    n_second = w_div_quo;
                    n_main   = W_MAIN'(r_qa);
                    n_state  = ST_OUT;
                end
            end
            ST_MUL: begin
                n_main  = W_MAIN'(w_prod);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_req   <= '0;
            r_sa    <= '0;
            r_sb    <= '0;
            r_dvd   <= '0;
            r_dvs   <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_req   <= n_req;
            r_sa    <= n_sa;
            r_sb    <= n_sb;
            r_dvd   <= n_dvd;
            r_dvs   <= n_dvs;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        r_qa     <= n_qa;
        r_main   <= n_main;
        r_second <= n_second;
        r_flag   <= n_flag;
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = (r_state == ST_OUT);
    assign o_result_main   = r_main;
    assign o_result_second = W_IN'(r_second);
    assign o_div_zero      = r_flag;

    // A finished run always leaves a zero divisor.
    `EGL_ASSERT_IMP(a_out_dvs_zero, r_state == ST_OUT, r_dvs == '0, "divisor not zero at result")
    // The divider is never started while busy.
    `EGL_ASSERT_IMP(a_start_idle_div, r_go, !w_div_stat.busy, "divider started while busy")
    // A division-by-zero result carries zero values.
    `EGL_ASSERT_IMP(a_flag_zero, o_valid && r_flag, r_main == '0 && r_second == '0,
        "nonzero result with error flag")
    // An accepted transaction leaves the idle state.
    `EGL_ASSERT_NXT(a_accept_busy, i_valid && !o_stall, r_state != ST_IDLE,
        "idle after acceptance")

endmodule

FILE: bench/euclid_gcd_lcm_fraction_reducer_tb.sv
// Self-checking testbench for the GCD, LCM and fraction reducer with a queue-fed driver.
`timescale 1ns / 1ps

module euclid_gcd_lcm_fraction_reducer_tb;

    import egl_pkg::*;

    // The one request code the package leaves unnamed; it yields zero results.
    localparam logic [W_REQ-1:0] REQ_UNUSED = 2'd3;

    localparam logic [63:0] OPW_MASK_WIDE = (64'd1 << OPW) - 64'd1;
    localparam logic [W_IN-1:0] OPW_MASK = OPW_MASK_WIDE[W_IN-1:0];

    // Slowest request: the worst Euclid run plus the two closing divisions.
    localparam int SETTLE_CYCLES = 2 + 49 * (OPW + 2);
    localparam int WATCHDOG_LIMIT = 10 * SETTLE_CYCLES;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct {
        logic [W_REQ-1:0] req;
        logic [W_IN-1:0]  a;
        logic [W_IN-1:0]  b;
        bit               drain_first;
    } t_request;

    typedef struct {
        logic [W_MAIN-1:0] main_val;
        logic [W_IN-1:0]   second_val;
        logic              div_zero;
    } t_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [W_REQ-1:0]    i_req_type = '0;
    logic [W_IN-1:0]     i_operand_a = '0;
    logic [W_IN-1:0]     i_operand_b = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [W_MAIN-1:0]   o_result_main;
    logic [W_IN-1:0]     o_result_second;
    logic                o_div_zero;

    t_request request_q[$];
    t_answer  answer_q[$];
    bit       in_fire = 1'b0;
    int       error_count = 0;
    int       idle_cycles = 0;
    int       items_sent = 0;
    int       total_items = 0;

    // Shadow of the block's working registers.
    logic [W_IN-1:0]  shadow_dividend;
    logic [W_IN-1:0]  shadow_divisor;
    logic [W_IN-1:0]  shadow_a;
    logic [W_IN-1:0]  shadow_b;
    logic [W_REQ-1:0] shadow_req;

    euclid_gcd_lcm_fraction_reducer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_main   (o_result_main),
        .o_result_second (o_result_second),
        .o_div_zero      (o_div_zero)
    );

    always #6 i_clk = ~i_clk;

    // Computes the answer to one request and updates the shadow registers.
    function automatic t_answer compute_answer(logic [W_REQ-1:0] req, logic [W_IN-1:0] a_in,
                                               logic [W_IN-1:0] b_in);
        t_answer ans;
        logic [W_IN-1:0] a;
        logic [W_IN-1:0] b;
        logic [W_IN-1:0] dvd;
        logic [W_IN-1:0] dvs;
        logic [W_IN-1:0] rem;
        logic [63:0] product;
        a = a_in & OPW_MASK;
        b = b_in & OPW_MASK;
        ans.main_val = '0;
        ans.second_val = '0;
        ans.div_zero = 1'b0;
        shadow_a = a;
        shadow_b = b;
        shadow_req = req;
        if (b == '0) begin
            shadow_dividend = a;
            shadow_divisor = '0;
            ans.div_zero = 1'b1;
        end else begin
            // Repeated remainders until the divisor runs out.
            dvd = a;
            dvs = b;
            while (dvs != '0) begin
                rem = dvd % dvs;
                dvd = dvs;
                dvs = rem;
            end
            shadow_dividend = dvd;
            shadow_divisor = dvs;
            case (req)
                REQ_GCD: begin
                    ans.main_val = {32'd0, dvd};
                end
                REQ_LCM: begin
                    product = {32'd0, a} * {32'd0, b};
                    ans.main_val = product / {32'd0, dvd};
                end
                REQ_FRAC: begin
                    ans.main_val = {32'd0, a / dvd};
                    ans.second_val = b / dvd;
                end
                default: begin
                    ans.main_val = '0;
                end
            endcase
        end
        return ans;
    endfunction

    // Random operand: mostly narrow values, sometimes the full width.
    function automatic logic [W_IN-1:0] random_operand();
        int width;
        logic [63:0] mask;
        if ($urandom_range(0, 99) < 40) begin
            return $urandom;
        end
        width = $urandom_range(1, 32);
        mask = (64'd1 << width) - 64'd1;
        return $urandom & mask[31:0];
    endfunction

    task automatic add_request(logic [W_REQ-1:0] req, logic [W_IN-1:0] a, logic [W_IN-1:0] b,
                               bit drain_first);
        t_request r;
        r.req = req;
        r.a = a;
        r.b = b;
        r.drain_first = drain_first;
        request_q.push_back(r);
    endtask

    // Driver and receiver: inputs change on the falling edge.
    always @(negedge i_clk) begin : drive
        t_request nxt;
        int tx_idle;
        int rx_idle;
        if (i_rst_n) begin
            if (items_sent < total_items / 3) begin
                tx_idle = 15;
                rx_idle = 83;
            end else if (items_sent < (2 * total_items) / 3) begin
                tx_idle = 83;
                rx_idle = 15;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            i_stall <= ($urandom_range(0, 99) < rx_idle);
            // A new transaction may only be offered once the previous one is taken.
            if (!i_valid || in_fire) begin
                if (request_q.size() == 0 || $urandom_range(0, 99) < tx_idle ||
                    (request_q[0].drain_first && answer_q.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt = request_q.pop_front();
                    i_valid <= 1'b1;
                    i_req_type <= nxt.req;
                    i_operand_a <= nxt.a;
                    i_operand_b <= nxt.b;
                    items_sent++;
                end
            end
        end
    end

    // Monitor: predicts on input transactions, checks output transactions, runs the watchdog.
    always @(posedge i_clk) begin : observe
        t_answer exp_ans;
        bit any_fire;
        if (i_rst_n) begin
            in_fire <= i_valid && !o_stall;
            any_fire = 1'b0;
            if (i_valid && !o_stall) begin
                answer_q.push_back(compute_answer(i_req_type, i_operand_a, i_operand_b));
                any_fire = 1'b1;
            end
            if (o_valid && !i_stall) begin
                any_fire = 1'b1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result main=%h second=%h div_zero=%b",
                             $time, o_result_main, o_result_second, o_div_zero);
                    error_count++;
                end else begin
                    exp_ans = answer_q.pop_front();
                    if (o_result_main !== exp_ans.main_val) begin
                        $display("%0t: result_main expected %h actual %h",
                                 $time, exp_ans.main_val, o_result_main);
                        error_count++;
                    end
                    if (o_result_second !== exp_ans.second_val) begin
                        $display("%0t: result_second expected %h actual %h",
                                 $time, exp_ans.second_val, o_result_second);
                        error_count++;
                    end
                    if (o_div_zero !== exp_ans.div_zero) begin
                        $display("%0t: div_zero expected %b actual %b",
                                 $time, exp_ans.div_zero, o_div_zero);
                        error_count++;
                    end
                end
            end
            // Stop the run if nothing moves for too long.
            if (any_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog expired", $time);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        logic [W_REQ-1:0] req;
        logic [W_IN-1:0] a;
        logic [W_IN-1:0] b;
        logic [W_IN-1:0] g;
        int pick;

        // Zero second operand under every request code.
        add_request(REQ_GCD, 32'd0, 32'd0, 1'b0);
        add_request(REQ_LCM, 32'hFFFF_FFFF, 32'd0, 1'b0);
        add_request(REQ_FRAC, 32'd0, 32'd0, 1'b0);
        add_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'd0, 1'b0);
        // Zero first operand.
        add_request(REQ_GCD, 32'd0, 32'hFFFF_FFFF, 1'b0);
        add_request(REQ_LCM, 32'd0, 32'hFFFF_FFFF, 1'b0);
        add_request(REQ_FRAC, 32'd0, 32'hFFFF_FFFF, 1'b0);
        // Largest operands under every request code.
        add_request(REQ_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(REQ_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(REQ_FRAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(REQ_FRAC, 32'hFFFF_FFFF, 32'd1, 1'b0);
        add_request(REQ_LCM, 32'd1, 32'hFFFF_FFFF, 1'b0);
        // Consecutive Fibonacci numbers give the longest Euclid run.
        add_request(REQ_GCD, 32'd2971215073, 32'd1836311903, 1'b0);
        add_request(REQ_FRAC, 32'd1836311903, 32'd2971215073, 1'b0);
        // Coprime neighbors give an LCM close to the top of 64 bits.
        add_request(REQ_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        add_request(REQ_GCD, 32'd12, 32'd18, 1'b0);
        add_request(REQ_LCM, 32'd12, 32'd18, 1'b0);
        add_request(REQ_FRAC, 32'd12, 32'd18, 1'b0);
        add_request(REQ_UNUSED, 32'd12, 32'd18, 1'b0);
        add_request(REQ_FRAC, 32'h8000_0000, 32'h4000_0000, 1'b0);
        add_request(REQ_GCD, 32'd1, 32'd1, 1'b0);

        // Random requests; some share a factor so the GCD is not trivial.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            req = W_REQ'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                g = $urandom_range(1, 65535);
                a = g * ($urandom & 32'hFFFF);
                b = g * ($urandom & 32'hFFFF);
            end else begin
                a = random_operand();
                b = random_operand();
            end
            if ($urandom_range(0, 99) < 5) begin
                a = '0;
            end
            if ($urandom_range(0, 99) < 5) begin
                b = '0;
            end
            add_request(req, a, b, (i == 0) || ($urandom_range(0, 99) == 0));
        end
        total_items = request_q.size();
        // Force a full drain at each idling phase boundary as well.
        request_q[total_items / 3].drain_first = 1'b1;
        request_q[(2 * total_items) / 3].drain_first = 1'b1;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and answered, then watch for stray results.
        // The check runs at the rising edge, where the driver's outputs are settled.
        while (request_q.size() != 0 || i_valid || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
